FILE: rtl/core/rfd_pkg.sv
// package: constants, register indexes and event codes of the refill event detector
`timescale 1ns / 1ps

package rfd_pkg;

  localparam int WIN_DEPTH = 10;
  localparam int SAMPLE_W  = 24;

  localparam int PTR_W  = $clog2(WIN_DEPTH);
  localparam int FILL_W = $clog2(WIN_DEPTH + 1);
  localparam int DIFF_W = SAMPLE_W + 1;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int WARM_W    = 8;
  localparam int THR_W     = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REFILL = 2'd3;

  localparam logic [WARM_W-1:0] WARMUP_RST     = 8'd30;
  localparam logic [THR_W-1:0]  RISE_THR_RST   = 16'd300;
  localparam logic [THR_W-1:0]  STABLE_RST     = 16'd300;
  localparam logic [THR_W-1:0]  MIN_REFILL_RST = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_START    = 2'd1,
    EV_COMPLETE = 2'd2,
    EV_CANCEL   = 2'd3
  } event_t;

endpackage

FILE: rtl/core/refill_event_detector_unit.sv
// top level: refill event detector over a sliding window of weight samples
`timescale 1ns / 1ps

// channel  | direction | handshake             | payload
// in_      | input     | in_valid / in_ready   | in_weight
// out_     | output    | out_valid / out_ready | out_event_res, out_refilling,
//          |           |                       | out_start_weight, out_refilled_amount
// cfg_     | input     | cfg_we                | cfg_index, cfg_wdata
//
// warm-up or window-filling item: write step, then decide step, where the result is registered
// full window: write step, window scan, then decide step, where the result is registered:
// one window write, one read per entry, a check of the last entry, the decision
// a new item is taken whenever the sequencer is idle, even while a result waits
// reset clears control and configuration; the window ram needs no clearing pass
// a stalled output holds the sequencer in its decision step until the result moves

module refill_event_detector_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rfd_pkg::SAMPLE_W-1:0] in_weight,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_res,
  output logic                                out_refilling,
  output logic signed [rfd_pkg::SAMPLE_W-1:0] out_start_weight,
  output logic signed [rfd_pkg::DIFF_W-1:0]   out_refilled_amount,
  input  logic                                cfg_we,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rfd_pkg::CFG_W-1:0]           cfg_wdata
);

  import rfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WRITE  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_DECIDE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [WARM_W-1:0] warm_r;
  logic [THR_W-1:0]  thr_r, band_r, min_r;

  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic [WARM_W-1:0]          skip_r, skip_nxt;
  logic [FILL_W-1:0]          fill_r, fill_nxt;
  logic [PTR_W-1:0]           wr_ptr_r, wr_ptr_nxt;
  logic                       active_r, active_nxt;
  logic signed [SAMPLE_W-1:0] start_r, start_nxt;
  logic                       eval_r, eval_nxt;
  logic [FILL_W-1:0]          scan_cnt_r, scan_cnt_nxt;
  logic                       rd_vld_r, rd_vld_nxt;
  logic [PTR_W-1:0]           rd_tag_r, rd_tag_nxt;
  logic signed [SAMPLE_W-1:0] oldest_r, oldest_nxt;
  logic                       stable_r, stable_nxt;

  logic                       out_valid_r, out_valid_nxt;
  event_t                     out_ev_r, out_ev_nxt;
  logic                       out_act_r, out_act_nxt;
  logic signed [SAMPLE_W-1:0] out_start_r, out_start_nxt;
  logic signed [DIFF_W-1:0]   out_amt_r, out_amt_nxt;

  // window ram
  logic signed [SAMPLE_W-1:0] win_mem [WIN_DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       mem_we;
  logic                       rd_en;

  // datapath
  logic signed [DIFF_W-1:0]   scan_diff;
  logic [DIFF_W-1:0]          scan_abs;
  logic signed [DIFF_W-1:0]   rise_diff;
  logic                       rise_hit;
  logic                       start_now;
  logic signed [SAMPLE_W-1:0] start_sel;
  logic                       act_mid;
  logic signed [DIFF_W-1:0]   gain;
  logic                       end_hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= WARMUP_RST;
      thr_r  <= RISE_THR_RST;
      band_r <= STABLE_RST;
      min_r  <= MIN_REFILL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WARMUP:     warm_r <= cfg_wdata[WARM_W-1:0];
        CFG_RISE_THR:   thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_STABLE:     band_r <= cfg_wdata[THR_W-1:0];
        CFG_MIN_REFILL: min_r  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wr_ptr_r] <= x_r;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[scan_cnt_r[PTR_W-1:0]];
    end
  end

  assign scan_diff = $signed({x_r[SAMPLE_W-1], x_r}) - $signed({rd_data_r[SAMPLE_W-1], rd_data_r});
  assign scan_abs  = scan_diff[DIFF_W-1] ? DIFF_W'(-scan_diff) : DIFF_W'(scan_diff);

  assign rise_diff = $signed({x_r[SAMPLE_W-1], x_r}) - $signed({oldest_r[SAMPLE_W-1], oldest_r});
  assign rise_hit  = rise_diff >= $signed(DIFF_W'(thr_r));
  assign start_now = eval_r && rise_hit && !active_r;
  assign start_sel = start_now ? oldest_r : start_r;
  assign act_mid   = active_r || start_now;
  assign gain      = $signed({x_r[SAMPLE_W-1], x_r}) - $signed({start_sel[SAMPLE_W-1], start_sel});
  assign end_hit   = eval_r && act_mid && stable_r;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    skip_nxt      = skip_r;
    fill_nxt      = fill_r;
    wr_ptr_nxt    = wr_ptr_r;
    active_nxt    = active_r;
    start_nxt     = start_r;
    eval_nxt      = eval_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_tag_nxt    = rd_tag_r;
    oldest_nxt    = oldest_r;
    stable_nxt    = stable_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ev_nxt    = out_ev_r;
    out_act_nxt   = out_act_r;
    out_start_nxt = out_start_r;
    out_amt_nxt   = out_amt_r;
    mem_we        = 1'b0;
    rd_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_weight;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        scan_cnt_nxt = '0;
        stable_nxt   = 1'b1;
        if (skip_r < warm_r) begin
          skip_nxt  = skip_r + 1'b1;
          eval_nxt  = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          mem_we     = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == PTR_W'(WIN_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
          if (fill_r < FILL_W'(WIN_DEPTH)) begin
            fill_nxt = fill_r + 1'b1;
          end
          // window counts as full once this sample lands
          eval_nxt  = (fill_r >= FILL_W'(WIN_DEPTH - 1));
          state_nxt = (fill_r >= FILL_W'(WIN_DEPTH - 1)) ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        rd_en = (scan_cnt_r < FILL_W'(WIN_DEPTH));
        if (rd_en) begin
          rd_vld_nxt   = 1'b1;
          rd_tag_nxt   = scan_cnt_r[PTR_W-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (scan_abs >= DIFF_W'(band_r)) begin
            stable_nxt = 1'b0;
          end
          // write pointer now marks the oldest entry
          if (rd_tag_r == wr_ptr_r) begin
            oldest_nxt = rd_data_r;
          end
          if (rd_tag_r == PTR_W'(WIN_DEPTH - 1)) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = start_sel;
          start_nxt     = start_sel;
          if (end_hit) begin
            out_ev_nxt  = (gain >= $signed(DIFF_W'(min_r))) ? EV_COMPLETE : EV_CANCEL;
            out_amt_nxt = gain;
            out_act_nxt = 1'b0;
            active_nxt  = 1'b0;
          end else begin
            out_ev_nxt  = start_now ? EV_START : EV_NONE;
            out_amt_nxt = '0;
            out_act_nxt = act_mid;
            active_nxt  = act_mid;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      skip_r      <= '0;
      fill_r      <= '0;
      wr_ptr_r    <= '0;
      active_r    <= 1'b0;
      start_r     <= '0;
      eval_r      <= 1'b0;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      stable_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      skip_r      <= skip_nxt;
      fill_r      <= fill_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      active_r    <= active_nxt;
      start_r     <= start_nxt;
      eval_r      <= eval_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      stable_r    <= stable_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    rd_tag_r    <= rd_tag_nxt;
    oldest_r    <= oldest_nxt;
    out_ev_r    <= out_ev_nxt;
    out_act_r   <= out_act_nxt;
    out_start_r <= out_start_nxt;
    out_amt_r   <= out_amt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_event_res       = out_ev_r;
  assign out_refilling       = out_act_r;
  assign out_start_weight    = out_start_r;
  assign out_refilled_amount = out_amt_r;

  a_start_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_ev_r == EV_START) |-> out_act_r)
    else $error("refill start reported without refill flag");

  a_end_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_ev_r == EV_COMPLETE || out_ev_r == EV_CANCEL) |-> !out_act_r)
    else $error("refill end reported with refill flag still set");

  a_amount_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_ev_r == EV_NONE || out_ev_r == EV_START) |-> (out_amt_r == '0))
    else $error("refilled amount nonzero without an end event");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WIN_DEPTH))
    else $error("fill count beyond window depth");

  a_scan_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (fill_r == FILL_W'(WIN_DEPTH)) && eval_r)
    else $error("window scan started before window filled");

endmodule
